// ----- sv/spms_pkg.sv -----
`timescale 1ns / 1ps
// Package for the shared-pool multi-stack block.
// Holds default sizes, field widths and the operation and status codes.
// No dependencies.

package spms_pkg;

  // Default sizes handed to the top level as parameter defaults.
  localparam int NUM_STACKS_DEF = 4;
  localparam int POOL_SIZE_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths of the transaction ports.
  localparam int SID_W    = 2;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;

  // Operation codes carried on in_kind.
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// ----- sv/shared_pool_multi_stack.sv -----
`timescale 1ns / 1ps
// Top level of the shared-pool multi-stack block: sequencer and state registers.
// Depends on spms_pkg, spms_slot_mem and spms_top_mem.
//
// Usage:
//   Several LIFO stacks share one pool of POOL_SIZE slots; free slots form a
//   linked free list. A command is taken at a rising edge with start high and
//   busy low: in_kind selects push or pop, in_stack_id the stack, and
//   in_push_value the value stored by a push.
//   Every command gives exactly one result: out_valid is high for one cycle
//   with out_status (ok, pool full, stack empty) and out_pop_value (the value
//   removed by a successful pop, else zero). The receiver cannot stall; the
//   result is taken in the cycle it is shown.
//   Sequence: a successful command passes through the top-read state and then
//   the slot-read state before out_valid rises; a failed one is reported
//   straight from the top-read state. busy stays high until the result is
//   registered, so a new command is taken only once the last one is done.
//   The order is set by two dependent memory reads: the stack-top memory,
//   then the slot memory at the slot it names.
//   Reset (synchronous, rst_n low) empties every stack and restores the full
//   free list at once: slots never allocated since reset are tracked by a
//   fill count, so no clearing pass is needed.

module shared_pool_multi_stack #(
  parameter int NUM_STACKS = spms_pkg::NUM_STACKS_DEF,
  parameter int POOL_SIZE  = spms_pkg::POOL_SIZE_DEF,
  parameter int DATA_WIDTH = spms_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_kind,
  input  logic        [spms_pkg::SID_W-1:0]    in_stack_id,
  input  logic signed [spms_pkg::VAL_W-1:0]    in_push_value,
  output logic                                 out_valid,
  output logic        [spms_pkg::STATUS_W-1:0] out_status,
  output logic signed [spms_pkg::VAL_W-1:0]    out_pop_value
);

  localparam int IDX_W     = $clog2(POOL_SIZE);
  localparam int LINK_W    = $clog2(POOL_SIZE + 1);
  localparam int ENTRY_W   = LINK_W + DATA_WIDTH;
  localparam int STK_W     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int SID_EXT_W = STK_W + spms_pkg::SID_W;
  localparam int VAL_EXT_W = (DATA_WIDTH > spms_pkg::VAL_W) ? DATA_WIDTH : spms_pkg::VAL_W;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SIZE);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TOP,
    S_SLOT
  } state_t;

  state_t                       state_r, state_nxt;
  logic                         out_valid_r, out_valid_nxt;
  spms_pkg::status_t            out_status_r, out_status_nxt;
  logic [spms_pkg::VAL_W-1:0]   out_pop_value_r, out_pop_value_nxt;

  logic [LINK_W-1:0]            free_head_r, free_head_nxt;
  logic [LINK_W-1:0]            hwm_r, hwm_nxt;

  logic                         kind_r;
  logic                         sid_ok_r;
  logic [STK_W-1:0]             sid_idx_r;
  logic [DATA_WIDTH-1:0]        value_r;
  logic [LINK_W-1:0]            top_r;
  logic [IDX_W-1:0]             slot_r;
  logic                         unwritten_r;

  logic                         accept;
  logic [SID_EXT_W-1:0]         sid_full;
  logic                         sid_ok;
  logic [VAL_EXT_W-1:0]         in_value_ext;

  logic                         top_rd_en;
  logic [LINK_W-1:0]            top_rd_data;
  logic                         top_wr_en;
  logic [LINK_W-1:0]            top_wr_data;

  logic                         slot_rd_en;
  logic [IDX_W-1:0]             slot_sel;
  logic [ENTRY_W-1:0]           slot_rd_data;
  logic                         slot_wr_en;
  logic [ENTRY_W-1:0]           slot_wr_data;

  logic                         op_fail;
  logic [LINK_W-1:0]            rd_link;
  logic [DATA_WIDTH-1:0]        rd_value;
  logic [LINK_W-1:0]            link_raw;
  logic [LINK_W-1:0]            link_n;
  logic [LINK_W-1:0]            top_n;
  logic [LINK_W-1:0]            free_head_n;
  logic [VAL_EXT_W-1:0]         rd_value_ext;

  // Command decode at the accepting edge.
  assign busy         = (state_r != S_IDLE);
  assign accept       = start && !busy;
  assign sid_full     = SID_EXT_W'(in_stack_id);
  assign sid_ok       = (sid_full < SID_EXT_W'(NUM_STACKS));
  assign in_value_ext = VAL_EXT_W'(unsigned'(in_push_value));
  assign top_rd_en    = accept && sid_ok;

  // Top-read cycle: decide failure and pick the slot to read.
  always_comb begin
    if (kind_r == spms_pkg::KIND_POP) begin
      op_fail  = !sid_ok_r || !(top_rd_data < NULL_LINK);
      slot_sel = top_rd_data[IDX_W-1:0];
    end else begin
      op_fail  = !sid_ok_r || !(free_head_r < NULL_LINK);
      slot_sel = free_head_r[IDX_W-1:0];
    end
  end

  assign slot_rd_en = (state_r == S_TOP) && !op_fail;

  // Slot-read cycle: resolve links. A slot at or above the fill count has never
  // been written; its link is taken to be simply the next slot index.
  assign rd_link      = slot_rd_data[DATA_WIDTH +: LINK_W];
  assign rd_value     = slot_rd_data[DATA_WIDTH-1:0];
  assign link_raw     = unwritten_r ? (LINK_W'(slot_r) + LINK_W'(1)) : rd_link;
  assign link_n       = (link_raw < NULL_LINK) ? link_raw : NULL_LINK;
  assign top_n        = (top_r < NULL_LINK) ? top_r : NULL_LINK;
  assign free_head_n  = (free_head_r < NULL_LINK) ? free_head_r : NULL_LINK;
  assign rd_value_ext = VAL_EXT_W'(rd_value);

  // Write-back of the slot entry and the stack top.
  always_comb begin
    slot_wr_en   = (state_r == S_SLOT);
    top_wr_en    = (state_r == S_SLOT);
    if (kind_r == spms_pkg::KIND_POP) begin
      slot_wr_data = {free_head_n, rd_value};
      top_wr_data  = link_n;
    end else begin
      slot_wr_data = {top_n, value_r};
      top_wr_data  = LINK_W'(slot_r);
    end
  end

  // Next state, result and free-list registers.
  always_comb begin
    state_nxt         = state_r;
    out_valid_nxt     = 1'b0;
    out_status_nxt    = out_status_r;
    out_pop_value_nxt = out_pop_value_r;
    free_head_nxt     = free_head_r;
    hwm_nxt           = hwm_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_TOP;
        end
      end
      S_TOP: begin
        if (op_fail) begin
          state_nxt         = S_IDLE;
          out_valid_nxt     = 1'b1;
          out_status_nxt    = (kind_r == spms_pkg::KIND_POP) ? spms_pkg::ST_EMPTY
                                                              : spms_pkg::ST_FULL;
          out_pop_value_nxt = '0;
        end else begin
          state_nxt = S_SLOT;
        end
      end
      S_SLOT: begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = spms_pkg::ST_OK;
        if (kind_r == spms_pkg::KIND_POP) begin
          out_pop_value_nxt = rd_value_ext[spms_pkg::VAL_W-1:0];
          free_head_nxt     = LINK_W'(slot_r);
        end else begin
          out_pop_value_nxt = '0;
          free_head_nxt     = link_n;
          if (unwritten_r) begin
            hwm_nxt = LINK_W'(slot_r) + LINK_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State machine, registered outputs and free-list control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      out_status_r    <= spms_pkg::ST_OK;
      out_pop_value_r <= '0;
      free_head_r     <= '0;
      hwm_r           <= '0;
    end else begin
      state_r         <= state_nxt;
      out_valid_r     <= out_valid_nxt;
      out_status_r    <= out_status_nxt;
      out_pop_value_r <= out_pop_value_nxt;
      free_head_r     <= free_head_nxt;
      hwm_r           <= hwm_nxt;
    end
  end

  // Command payload and per-operation working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= in_kind;
      sid_ok_r  <= sid_ok;
      sid_idx_r <= sid_full[STK_W-1:0];
      value_r   <= in_value_ext[DATA_WIDTH-1:0];
    end
    if (slot_rd_en) begin
      top_r       <= top_rd_data;
      slot_r      <= slot_sel;
      unwritten_r <= (LINK_W'(slot_sel) >= hwm_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_pop_value = signed'(out_pop_value_r);

  // Stack-top memory.
  spms_top_mem #(
    .NUM_STACKS (NUM_STACKS),
    .POOL_SIZE  (POOL_SIZE)
  ) u_top_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (top_rd_en),
    .rd_addr (sid_full[STK_W-1:0]),
    .rd_data (top_rd_data),
    .wr_en   (top_wr_en),
    .wr_addr (sid_idx_r),
    .wr_data (top_wr_data)
  );

  // Slot memory holding links and values.
  spms_slot_mem #(
    .POOL_SIZE  (POOL_SIZE),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_slot_mem (
    .clk     (clk),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_sel),
    .rd_data (slot_rd_data),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_r),
    .wr_data (slot_wr_data)
  );

  // A result only follows a command in flight.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) != S_IDLE)
    else $error("result strobe without a command in flight");

  // Any failed command reports a zero value.
  a_fail_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != spms_pkg::ST_OK) |-> out_pop_value == '0)
    else $error("failed command returned a nonzero value");

  // A pushed slot is always at or below the fill count.
  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SLOT && kind_r == spms_pkg::KIND_PUSH) |->
      LINK_W'(slot_r) <= hwm_r)
    else $error("push skipped an unallocated slot");

  // An accepted command always starts with the top read.
  a_accept_to_top: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_TOP)
    else $error("accepted command did not start");

endmodule

// ----- sv/spms_slot_mem.sv -----
`timescale 1ns / 1ps
// Slot memory of the shared pool: one entry per slot holding {link, value}.
// Synchronous write, one read port with registered data. Uses spms_pkg.

module spms_slot_mem #(
  parameter int POOL_SIZE  = spms_pkg::POOL_SIZE_DEF,
  parameter int DATA_WIDTH = spms_pkg::DATA_WIDTH_DEF,
  localparam int IDX_W     = $clog2(POOL_SIZE),
  localparam int LINK_W    = $clog2(POOL_SIZE + 1),
  localparam int ENTRY_W   = LINK_W + DATA_WIDTH
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [ENTRY_W-1:0] rd_data,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [ENTRY_W-1:0] wr_data
);

  logic [ENTRY_W-1:0] mem [POOL_SIZE];
  logic [ENTRY_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/spms_top_mem.sv -----
`timescale 1ns / 1ps
// Stack-top memory: one link per stack, registered read data.
// Entries never written since reset read as the null link. Uses spms_pkg.

module spms_top_mem #(
  parameter int NUM_STACKS = spms_pkg::NUM_STACKS_DEF,
  parameter int POOL_SIZE  = spms_pkg::POOL_SIZE_DEF,
  localparam int STK_W     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1,
  localparam int LINK_W    = $clog2(POOL_SIZE + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [STK_W-1:0]  rd_addr,
  output logic [LINK_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [STK_W-1:0]  wr_addr,
  input  logic [LINK_W-1:0] wr_data
);

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SIZE);

  logic [LINK_W-1:0]     mem [NUM_STACKS];
  logic [NUM_STACKS-1:0] valid_r;
  logic [LINK_W-1:0]     rd_mem_r;
  logic                  rd_valid_r;

  // Storage array, no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Per-entry valid bits; reset makes every stack empty at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read of data and valid bit.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_mem_r   <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? rd_mem_r : NULL_LINK;

endmodule
